// ===== src/ibis_telegram_framer_unit_assert.svh =====
// Assertion macros for the IBIS telegram framer.
`ifndef IBIS_TELEGRAM_FRAMER_UNIT_ASSERT_SVH
`define IBIS_TELEGRAM_FRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ITF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ITF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/itf_pkg.sv =====
// Shared types, byte constants and umlaut substitution table for the telegram framer.
package itf_pkg;

  typedef logic [7:0] byte_t;

  localparam byte_t LEAD_BYTE = 8'hC3;
  localparam byte_t CR_BYTE   = 8'h0D;
  localparam byte_t XOR_SEED  = 8'h7F;

  localparam int unsigned MAX_RESULTS = 4;

  // Map the byte after a 0xC3 lead to its line substitute; 0 means unknown.
  function automatic byte_t substitute(input byte_t second);
    byte_t sub;
    case (second)
      8'hA4:   sub = 8'h7B;
      8'hB6:   sub = 8'h7C;
      8'hBC:   sub = 8'h7D;
      8'h9F:   sub = 8'h7E;
      8'h84:   sub = 8'h5B;
      8'h96:   sub = 8'h5C;
      8'h9C:   sub = 8'h5D;
      default: sub = 8'h00;
    endcase
    return sub;
  endfunction

endpackage

// ===== src/ibis_telegram_framer_unit.sv =====
// IBIS telegram framer: umlaut substitution, CR and checksum insertion.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one body byte per request,
//   with in_body_end high on the final byte of the telegram body.
//   Output channel (out_valid / out_stall) carries line bytes; out_frame_end
//   is high on the checksum byte that closes the telegram.
//   A request is registered at acceptance, then expanded combinationally into
//   zero to four line bytes held in a small result buffer. The first line
//   byte shows on the output once the expansion of its request has passed
//   from the request register into the result buffer.
//   Plain body bytes flow at one byte per cycle while the receiver does not
//   stall. A request that expands into several line bytes (unknown follower
//   of 0xC3, or the body end with its CR and checksum) sends them one by
//   one; the input is stalled while the result buffer drains. A held 0xC3
//   yields no byte until the next request decides it.
//   When the receiver stalls, the current line byte holds, the buffer stops
//   draining, and the input stalls once the request register is full.
//   Reset (synchronous, active low) empties the buffer and request register,
//   drops any held lead byte and reloads the checksum seed 0x7F.
module ibis_telegram_framer_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  itf_pkg::byte_t in_body_byte,
  input  logic           in_body_end,
  output logic           out_valid,
  input  logic           out_stall,
  output itf_pkg::byte_t out_line_byte,
  output logic           out_frame_end
);
  import itf_pkg::*;

  // Request register.
  logic  s1_valid_r, s1_valid_nxt;
  byte_t s1_byte_r;
  logic  s1_end_r;

  // Framing state.
  logic  held_r, held_nxt;
  byte_t xor_r, xor_nxt;

  // Result buffer.
  byte_t      buf_byte_r [MAX_RESULTS];
  logic [3:0] buf_end_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] rd_r, rd_nxt;

  // Expansion of the registered request.
  byte_t      res_byte [MAX_RESULTS];
  logic [3:0] res_end;
  logic [2:0] res_cnt;
  byte_t      sub;
  logic       fresh;

  logic in_fire, out_fire, can_load, load;

  assign out_valid     = (cnt_r != 3'd0);
  assign out_line_byte = buf_byte_r[rd_r];
  assign out_frame_end = buf_end_r[rd_r];
  assign out_fire      = out_valid && !out_stall;

  // Load a new expansion when the buffer is empty or its last byte leaves now.
  assign can_load = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_fire);
  assign load     = s1_valid_r && can_load;
  assign in_stall = s1_valid_r && !can_load;
  assign in_fire  = in_valid && !in_stall;

  // Expand one body byte into line bytes, folding each one but the checksum byte into the checksum.
  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res_byte[i] = '0;
    end
    res_end  = '0;
    res_cnt  = '0;
    held_nxt = held_r;
    xor_nxt  = xor_r;
    fresh    = 1'b1;
    sub      = substitute(s1_byte_r);

    if (held_r) begin
      held_nxt = 1'b0;
      if (sub != 8'h00) begin
        res_byte[res_cnt[1:0]] = sub;
        xor_nxt = xor_nxt ^ sub;
        fresh   = 1'b0;
      end else begin
        res_byte[res_cnt[1:0]] = LEAD_BYTE;
        xor_nxt = xor_nxt ^ LEAD_BYTE;
      end
      res_cnt = res_cnt + 3'd1;
    end

    if (fresh) begin
      if (s1_byte_r == LEAD_BYTE) begin
        held_nxt = 1'b1;
      end else begin
        res_byte[res_cnt[1:0]] = s1_byte_r;
        xor_nxt = xor_nxt ^ s1_byte_r;
        res_cnt = res_cnt + 3'd1;
      end
    end

    if (s1_end_r) begin
      // Flush a lead byte still held at the body end.
      if (held_nxt) begin
        held_nxt = 1'b0;
        res_byte[res_cnt[1:0]] = LEAD_BYTE;
        xor_nxt = xor_nxt ^ LEAD_BYTE;
        res_cnt = res_cnt + 3'd1;
      end
      res_byte[res_cnt[1:0]] = CR_BYTE;
      xor_nxt = xor_nxt ^ CR_BYTE;
      res_cnt = res_cnt + 3'd1;
      res_byte[res_cnt[1:0]] = xor_nxt;
      res_end[res_cnt[1:0]]  = 1'b1;
      res_cnt = res_cnt + 3'd1;
      xor_nxt = XOR_SEED;
    end
  end

  // Buffer occupancy and read pointer.
  always_comb begin
    cnt_nxt = cnt_r;
    rd_nxt  = rd_r;
    if (load) begin
      cnt_nxt = res_cnt;
      rd_nxt  = '0;
    end else if (out_fire) begin
      cnt_nxt = cnt_r - 3'd1;
      rd_nxt  = rd_r + 2'd1;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (load) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      cnt_r      <= '0;
      rd_r       <= '0;
      held_r     <= 1'b0;
      xor_r      <= XOR_SEED;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      cnt_r      <= cnt_nxt;
      rd_r       <= rd_nxt;
      if (load) begin
        held_r <= held_nxt;
        xor_r  <= xor_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_body_byte;
      s1_end_r  <= in_body_end;
    end
    if (load) begin
      buf_byte_r <= res_byte;
      buf_end_r  <= res_end;
    end
  end

`include "ibis_telegram_framer_unit_assert.svh"

  `ITF_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= 3'd4, "result buffer count out of range")
  `ITF_ASSERT_NOW(a_end_is_last, out_valid && out_frame_end, cnt_r == 3'd1, "checksum not last")
  `ITF_ASSERT_NOW(a_stall_has_req, in_stall, s1_valid_r, "input stalled with no request held")
  `ITF_ASSERT_NEXT(a_end_resets, load && s1_end_r, !held_r && xor_r == XOR_SEED, "not reseeded")
  `ITF_ASSERT_NEXT(a_drain_continues, out_fire && (cnt_r > 3'd1), out_valid, "buffer lost bytes")

endmodule
